@@ src/swls_pkg.sv @@
// Package: shared types and constants of the sliding-window latency statistics block.
package swls_pkg;

	localparam int DATA_W = 16;

	localparam logic [DATA_W-1:0] GRAPH_FLOOR = 16'd8525;

	localparam int RANK_NUM = 99;
	localparam int RANK_DEN = 100;

	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_OLD,
		S_FILL,
		S_SORT,
		S_DIV,
		S_DONE
	} state_t;

endpackage

@@ src/sliding_window_latency_stats_top.sv @@
// Top level: sliding-window frame-time mean, 99th percentile and graph top.
//
// Input channel: frame_time with in_valid/in_stall. One transaction is taken
// when in_valid is high and in_stall is low. Output channel: mean_time,
// p99_time and graph_top with out_valid/out_stall; one result per input.
// Configuration: cfg_wr_en/cfg_wr_data write the enable bit; write it only
// while no transaction is in flight.
// When enable is low, a sample leaves the window alone and the current
// statistics go through the finish state to the output register.
// When enable is high, the result passes through the ring read, the first
// sorted-copy fetch, a merge pass over the sorted copy at one entry per
// cycle, then a step that forms the mean by a reciprocal multiply of the
// running sum.
// in_stall stays high until the result is loaded into the output register,
// so the next transaction can be taken in the following cycle.
// After reset both memories are swept to zero; in_stall stays high during
// that sweep. A stalled result holds in the output register; the next input
// is taken meanwhile, and its result waits in the finish state until the
// output register frees up.
module sliding_window_latency_stats_top #(
	parameter int WINDOW = 128
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wr_en,
	input  logic        cfg_wr_data,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [15:0] frame_time,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [15:0] mean_time,
	output logic [15:0] p99_time,
	output logic [15:0] graph_top
);

	localparam int AW   = (WINDOW > 2) ? $clog2(WINDOW) : 1;
	localparam int SW   = swls_pkg::DATA_W + AW;
	localparam int KSH  = SW + AW;
	localparam int PW   = 2 * SW + 1;
	localparam int RANK = (WINDOW * swls_pkg::RANK_NUM) / swls_pkg::RANK_DEN;

	localparam longint unsigned RECIP =
		((64'd1 << KSH) + 64'(WINDOW) - 64'd1) / 64'(WINDOW);

	localparam logic [AW-1:0]  LAST_IDX = AW'(WINDOW - 1);
	localparam logic [AW-1:0]  RANK_IDX = AW'(RANK);
	localparam logic [SW:0]    MEAN_MUL = (SW + 1)'(RECIP);
	localparam logic [AW:0]    WIN_END  = (AW + 1)'(WINDOW);

	swls_pkg::state_t state_q, state_d;

	logic          enable_q;
	logic [AW-1:0] slot_q;
	logic [AW-1:0] i_q;
	logic [SW-1:0] sum_q;
	logic          rmv_q;
	logic          ins_q;
	logic [15:0]   mean_q;
	logic [15:0]   p99_q;
	logic [15:0]   max_q;
	logic          out_valid_q;

	logic [15:0]   sample_q;
	logic [15:0]   old_q;
	logic [15:0]   cur_q;
	logic [15:0]   prev_q;
	logic [15:0]   mean_time_q;
	logic [15:0]   p99_time_q;
	logic [15:0]   graph_top_q;

	logic [15:0] ring_mem [WINDOW];
	logic [15:0] ring_rdata_q;
	logic          ring_we;
	logic [AW-1:0] ring_waddr;
	logic [15:0]   ring_wdata;

	logic [15:0] sort_mem [WINDOW];
	logic [15:0] sort_rdata_q;
	logic          sort_we;
	logic [AW-1:0] sort_waddr;
	logic [15:0]   sort_wdata;
	logic [AW-1:0] sort_raddr;

	logic          in_accept;
	logic          out_load;
	logic [AW:0]   ahead;
	logic [15:0]   step_v;
	logic          step_vld;
	logic          step_rmv;
	logic          step_ins;
	logic [PW-1:0] mean_prod;

	assign in_stall  = (state_q != swls_pkg::S_IDLE);
	assign in_accept = in_valid && !in_stall;
	assign out_load  = (state_q == swls_pkg::S_DONE) && (!out_valid_q || !out_stall);

	assign out_valid = out_valid_q;
	assign mean_time = mean_time_q;
	assign p99_time  = p99_time_q;
	assign graph_top = graph_top_q;

	always_ff @(posedge clk) begin
		if (ring_we) begin
			ring_mem[ring_waddr] <= ring_wdata;
		end
		ring_rdata_q <= ring_mem[slot_q];
	end

	always_ff @(posedge clk) begin
		if (sort_we) begin
			sort_mem[sort_waddr] <= sort_wdata;
		end
		sort_rdata_q <= sort_mem[sort_raddr];
	end

	always_comb begin
		step_v   = cur_q;
		step_vld = 1'b1;
		step_rmv = rmv_q;
		case ({rmv_q, ins_q})
			2'b00: begin
				if (cur_q == old_q) begin
					step_v   = sort_rdata_q;
					step_vld = (i_q != LAST_IDX);
					step_rmv = 1'b1;
				end
			end
			2'b01: begin
				if (prev_q == old_q) begin
					step_v   = cur_q;
					step_rmv = 1'b1;
				end else begin
					step_v = prev_q;
				end
			end
			2'b10: begin
				step_v   = sort_rdata_q;
				step_vld = (i_q != LAST_IDX);
			end
			2'b11: begin
				step_v = cur_q;
			end
			default: begin
				step_v = cur_q;
			end
		endcase
		step_ins = !ins_q && (!step_vld || (step_v > sample_q));
	end

	assign ahead = {1'b0, i_q} + (AW + 1)'(2);

	assign mean_prod = PW'(sum_q) * PW'(MEAN_MUL);

	always_comb begin
		state_d    = state_q;
		ring_we    = 1'b0;
		ring_waddr = slot_q;
		ring_wdata = frame_time;
		sort_we    = 1'b0;
		sort_waddr = i_q;
		sort_wdata = step_ins ? sample_q : step_v;
		sort_raddr = '0;
		case (state_q)
			swls_pkg::S_CLEAR: begin
				ring_we    = 1'b1;
				ring_waddr = i_q;
				ring_wdata = '0;
				sort_we    = 1'b1;
				sort_wdata = '0;
				if (i_q == LAST_IDX) begin
					state_d = swls_pkg::S_IDLE;
				end
			end
			swls_pkg::S_IDLE: begin
				if (in_accept) begin
					ring_we = enable_q;
					state_d = enable_q ? swls_pkg::S_OLD : swls_pkg::S_DONE;
				end
			end
			swls_pkg::S_OLD: begin
				state_d = swls_pkg::S_FILL;
			end
			swls_pkg::S_FILL: begin
				sort_raddr = AW'(1);
				state_d    = swls_pkg::S_SORT;
			end
			swls_pkg::S_SORT: begin
				sort_we = 1'b1;
				if (ahead < WIN_END) begin
					sort_raddr = ahead[AW-1:0];
				end
				if (i_q == LAST_IDX) begin
					state_d = swls_pkg::S_DIV;
				end
			end
			swls_pkg::S_DIV: begin
				state_d = swls_pkg::S_DONE;
			end
			swls_pkg::S_DONE: begin
				if (out_load) begin
					state_d = swls_pkg::S_IDLE;
				end
			end
			default: begin
				state_d = swls_pkg::S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= swls_pkg::S_CLEAR;
			enable_q    <= 1'b0;
			slot_q      <= '0;
			i_q         <= '0;
			sum_q       <= '0;
			rmv_q       <= 1'b0;
			ins_q       <= 1'b0;
			mean_q      <= '0;
			p99_q       <= '0;
			max_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_wr_en) begin
				enable_q <= cfg_wr_data;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				swls_pkg::S_CLEAR: begin
					i_q <= (i_q == LAST_IDX) ? '0 : i_q + AW'(1);
				end
				swls_pkg::S_IDLE: begin
					if (in_accept && enable_q) begin
						slot_q <= (slot_q == LAST_IDX) ? '0 : slot_q + AW'(1);
					end
				end
				swls_pkg::S_OLD: begin
					sum_q <= sum_q - SW'(ring_rdata_q) + SW'(sample_q);
					rmv_q <= 1'b0;
					ins_q <= 1'b0;
				end
				swls_pkg::S_FILL: begin
					i_q <= '0;
				end
				swls_pkg::S_SORT: begin
					rmv_q <= step_rmv;
					ins_q <= ins_q || step_ins;
					if (i_q == RANK_IDX) begin
						p99_q <= sort_wdata;
					end
					if (i_q == LAST_IDX) begin
						max_q <= sort_wdata;
						i_q   <= '0;
					end else begin
						i_q <= i_q + AW'(1);
					end
				end
				swls_pkg::S_DIV: begin
					mean_q <= mean_prod[KSH +: 16];
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_accept) begin
			sample_q <= frame_time;
		end
		if (state_q == swls_pkg::S_OLD) begin
			old_q <= ring_rdata_q;
		end
		if (state_q == swls_pkg::S_FILL || state_q == swls_pkg::S_SORT) begin
			prev_q <= cur_q;
			cur_q  <= sort_rdata_q;
		end
		if (out_load) begin
			mean_time_q <= mean_q;
			p99_time_q  <= p99_q;
			graph_top_q <= (max_q < swls_pkg::GRAPH_FLOOR) ? swls_pkg::GRAPH_FLOOR : max_q;
		end
	end

	a_merge_complete: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == swls_pkg::S_SORT && i_q == LAST_IDX) |=> ins_q)
		else $error("merge pass ended without inserting the sample");

	a_out_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> ($past(state_q) == swls_pkg::S_DONE))
		else $error("result raised outside the finish state");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(in_accept && enable_q) |=> (state_q == swls_pkg::S_OLD))
		else $error("enabled sample did not start the window update");

endmodule
